@@ src/hsv2rgb_pkg.sv @@
// Shared widths, constants and sector codes for the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int HUE_W     = 9;
    localparam int CH_W      = 8;
    localparam int SECTOR_W  = 4;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam int SECTOR_DEG = 60;
    localparam int SCALE      = 256;
    localparam int NUM_BOUNDS = 8;

    typedef logic [SECTOR_W-1:0] t_sector;

    localparam t_sector SECT_RED_YELLOW    = 4'd0;
    localparam t_sector SECT_YELLOW_GREEN  = 4'd1;
    localparam t_sector SECT_GREEN_CYAN    = 4'd2;
    localparam t_sector SECT_CYAN_BLUE     = 4'd3;
    localparam t_sector SECT_BLUE_MAGENTA  = 4'd4;

    typedef struct packed {
        t_sector          sector;
        logic [CH_W-1:0]  frac;
    } t_hue_split;

endpackage

@@ src/hsv2rgb_hue_split.sv @@
// Splits a hue angle into its 60-degree sector and a 0..250 fraction within it.
module hsv2rgb_hue_split (
    input  logic [hsv2rgb_pkg::HUE_W-1:0] i_hue,
    output hsv2rgb_pkg::t_hue_split       o_split
);
    import hsv2rgb_pkg::*;

    t_sector              sector;
    logic [HUE_W-1:0]     base;
    logic [HUE_W-1:0]     rem;
    logic [HUE_W+4-1:0]   rem_x17;

    // The sector is the number of 60-degree boundaries at or below the hue.
    always_comb begin
        sector = '0;
        for (int k = 1; k <= NUM_BOUNDS; k++) begin
            if (i_hue >= HUE_W'(k * SECTOR_DEG)) begin
                sector = sector + t_sector'(1);
            end
        end
    end

    assign base    = HUE_W'(sector) * HUE_W'(SECTOR_DEG);
    assign rem     = i_hue - base;
    // rem * 255 / 60 equals rem * 17 / 4 exactly.
    assign rem_x17 = {rem, 4'b0000} + {4'b0000, rem};

    assign o_split.sector = sector;
    assign o_split.frac   = rem_x17[CH_W+1:2];

endmodule

@@ src/hsv_to_rgb_converter_core.sv @@
// Top level of the pipelined HSV to RGB converter.
//
// Converts one HSV item per clock cycle, while the output is not stalled, into
// 8-bit red, green and blue. The datapath is a four-stage pipeline (hue split,
// saturation products, value products, channel selection), each with its own
// register. Throughput is one item per cycle while the output is not stalled;
// every stage holds its item while the stage after it is full and stalled,
// and the last stage register drives the output stream directly.
// Input tdata carries hue, saturation and brightness; output tdata carries
// red, green and blue. A saturation of zero yields grey at the given value.
module hsv_to_rgb_converter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // hue[8:0], saturation[16:9], brightness[24:17], zero fill above
    input  logic [hsv2rgb_pkg::S_TDATA_W-1:0]  i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [hsv2rgb_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    import hsv2rgb_pkg::*;

    logic [HUE_W-1:0] in_hue;
    logic [CH_W-1:0]  in_sat;
    logic [CH_W-1:0]  in_val;
    t_hue_split       split;

    logic             s1_en, s2_en, s3_en, s4_en;

    logic             r1_vld;
    t_sector          r1_sector;
    logic [CH_W-1:0]  r1_frac, r1_sat, r1_val;

    logic             r2_vld;
    t_sector          r2_sector;
    logic [CH_W-1:0]  r2_sat, r2_val, r2_red_q, r2_red_t;

    logic             r3_vld;
    t_sector          r3_sector;
    logic [CH_W-1:0]  r3_val, r3_p, r3_q, r3_t;

    logic             r4_vld;
    logic [CH_W-1:0]  r4_red, r4_green, r4_blue;

    logic [2*CH_W-1:0] n_prod_q;
    logic [2*CH_W:0]   n_prod_t;
    logic [2*CH_W:0]   n_prod_p3, n_prod_q3, n_prod_t3;
    logic [CH_W-1:0]   n_red, n_green, n_blue;

    assign in_hue = i_s_tdata[HUE_W-1:0];
    assign in_sat = i_s_tdata[HUE_W+CH_W-1:HUE_W];
    assign in_val = i_s_tdata[HUE_W+2*CH_W-1:HUE_W+CH_W];

    hsv2rgb_hue_split u_hue_split (
        .i_hue   (in_hue),
        .o_split (split)
    );

    // A stage may load when it is empty or its contents move on this cycle.
    assign s4_en      = !r4_vld || i_m_tready;
    assign s3_en      = !r3_vld || s4_en;
    assign s2_en      = !r2_vld || s3_en;
    assign s1_en      = !r1_vld || s2_en;
    assign o_s_tready = s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (s1_en) r1_vld <= i_s_tvalid;
            if (s2_en) r2_vld <= r1_vld;
            if (s3_en) r3_vld <= r2_vld;
            if (s4_en) r4_vld <= r3_vld;
        end
    end

    // Reductions applied to the value for the q and t levels.
    assign n_prod_q = r1_sat * r1_frac;
    assign n_prod_t = r1_sat * ((CH_W+1)'(SCALE) - {1'b0, r1_frac});

    // Levels p, q and t, each at most the value.
    assign n_prod_p3 = r2_val * ((CH_W+1)'(SCALE) - {1'b0, r2_sat});
    assign n_prod_q3 = r2_val * ((CH_W+1)'(SCALE) - {1'b0, r2_red_q});
    assign n_prod_t3 = r2_val * ((CH_W+1)'(SCALE) - {1'b0, r2_red_t});

    always_comb begin
        unique case (r3_sector)
            SECT_RED_YELLOW: begin
                n_red = r3_val; n_green = r3_t;   n_blue = r3_p;
            end
            SECT_YELLOW_GREEN: begin
                n_red = r3_q;   n_green = r3_val; n_blue = r3_p;
            end
            SECT_GREEN_CYAN: begin
                n_red = r3_p;   n_green = r3_val; n_blue = r3_t;
            end
            SECT_CYAN_BLUE: begin
                n_red = r3_p;   n_green = r3_q;   n_blue = r3_val;
            end
            SECT_BLUE_MAGENTA: begin
                n_red = r3_t;   n_green = r3_p;   n_blue = r3_val;
            end
            default: begin
                n_red = r3_val; n_green = r3_p;   n_blue = r3_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r1_sector <= split.sector;
            r1_frac   <= split.frac;
            r1_sat    <= in_sat;
            r1_val    <= in_val;
        end
        if (s2_en) begin
            r2_sector <= r1_sector;
            r2_sat    <= r1_sat;
            r2_val    <= r1_val;
            r2_red_q  <= n_prod_q[2*CH_W-1:CH_W];
            r2_red_t  <= n_prod_t[2*CH_W-1:CH_W];
        end
        if (s3_en) begin
            r3_sector <= r2_sector;
            r3_val    <= r2_val;
            r3_p      <= n_prod_p3[2*CH_W-1:CH_W];
            r3_q      <= n_prod_q3[2*CH_W-1:CH_W];
            r3_t      <= n_prod_t3[2*CH_W-1:CH_W];
        end
        if (s4_en) begin
            r4_red   <= n_red;
            r4_green <= n_green;
            r4_blue  <= n_blue;
        end
    end

    assign o_m_tvalid = r4_vld;
    assign o_m_tdata  = {r4_blue, r4_green, r4_red};

endmodule
